// ----- rtl/tcpct_pkg.sv -----
// Package for the TCP connection tracker: item payload structs, flag codes,
// the one-hot lifecycle type and its mapping to the 4-bit state code.
// No dependencies.
`timescale 1ns / 1ps

package tcpct_pkg;

  localparam int unsigned MAX_RETRIES = 6;
  localparam int unsigned GAP_W       = 8;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned CODE_W      = 4;

  localparam logic [7:0] FL_SYN     = 8'h02;
  localparam logic [7:0] FL_ACK     = 8'h10;
  localparam logic [7:0] FL_SYN_ACK = 8'h12;
  localparam logic [7:0] FL_RST_ACK = 8'h14;
  localparam logic [7:0] FL_FIN_ACK = 8'h11;

  localparam logic [CODE_W-1:0] CODE_CLOSED = 4'd0;
  localparam logic [CODE_W-1:0] CODE_SYN    = 4'd1;
  localparam logic [CODE_W-1:0] CODE_SYNACK = 4'd8;
  localparam logic [CODE_W-1:0] CODE_ESTAB  = 4'd9;
  localparam logic [CODE_W-1:0] CODE_FIN1   = 4'd10;
  localparam logic [CODE_W-1:0] CODE_FIN2   = 4'd11;
  localparam logic [CODE_W-1:0] CODE_RESET  = 4'd12;

  typedef enum logic [12:0] {
    ST_CLOSED = 13'b0000000000001,
    ST_SYN    = 13'b0000000000010,
    ST_RETRY1 = 13'b0000000000100,
    ST_RETRY2 = 13'b0000000001000,
    ST_RETRY3 = 13'b0000000010000,
    ST_RETRY4 = 13'b0000000100000,
    ST_RETRY5 = 13'b0000001000000,
    ST_RETRY6 = 13'b0000010000000,
    ST_SYNACK = 13'b0000100000000,
    ST_ESTAB  = 13'b0001000000000,
    ST_FIN1   = 13'b0010000000000,
    ST_FIN2   = 13'b0100000000000,
    ST_RESET  = 13'b1000000000000
  } conn_state_t;

  typedef struct packed {
    logic [7:0]        flags;
    logic [TIME_W-1:0] time_sec;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] conn_state;
    logic              bad_packet;
    logic [CNT_W-1:0]  bad_total;
  } out_item_t;

  function automatic logic [CODE_W-1:0] state_code(input conn_state_t st);
    logic [CODE_W-1:0] code;
    unique case (st)
      ST_CLOSED: code = CODE_CLOSED;
      ST_SYN:    code = CODE_SYN;
      ST_RETRY1: code = 4'd2;
      ST_RETRY2: code = 4'd3;
      ST_RETRY3: code = 4'd4;
      ST_RETRY4: code = 4'd5;
      ST_RETRY5: code = 4'd6;
      ST_RETRY6: code = 4'd7;
      ST_SYNACK: code = CODE_SYNACK;
      ST_ESTAB:  code = CODE_ESTAB;
      ST_FIN1:   code = CODE_FIN1;
      ST_FIN2:   code = CODE_FIN2;
      ST_RESET:  code = CODE_RESET;
      default:   code = CODE_CLOSED;
    endcase
    return code;
  endfunction

  function automatic conn_state_t next_retry(input conn_state_t st);
    conn_state_t nx;
    unique case (st)
      ST_SYN:    nx = ST_RETRY1;
      ST_RETRY1: nx = ST_RETRY2;
      ST_RETRY2: nx = ST_RETRY3;
      ST_RETRY3: nx = ST_RETRY4;
      ST_RETRY4: nx = ST_RETRY5;
      ST_RETRY5: nx = ST_RETRY6;
      default:   nx = ST_SYN;
    endcase
    return nx;
  endfunction

endpackage

// ----- rtl/tcp_connection_tracker.sv -----
// Top level of the TCP connection tracker: input register, lifecycle update and
// result register with valid/stall handshakes on both sides. Depends on tcpct_pkg.
// Items wait in the input register until the result register can take them.
// Throughput: one item per cycle unless the output stalls; the lifecycle update
// with a 32-bit gap subtract and compare is combinational between the registers.
// Reset (synchronous, rst_n low) sets closed, zero SYN time and count, gap 1.
`timescale 1ns / 1ps

module tcp_connection_tracker
  import tcpct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_wr_en,
  input  logic [GAP_W-1:0]      cfg_wr_data
);

  logic              s1_valid_r;
  in_item_t          s1_item_r;
  logic              out_valid_r;
  out_item_t         out_item_r;
  logic [GAP_W-1:0]  gap_r;
  conn_state_t       state_r, state_nxt;
  logic [TIME_W-1:0] syn_time_r, syn_time_nxt;
  logic [CNT_W-1:0]  bad_cnt_r, bad_cnt_nxt;
  logic              bad;
  logic              out_ready;
  logic              adv;
  logic              s1_load;
  logic [CODE_W-1:0] code;
  logic [2:0]        retries;
  logic [TIME_W-1:0] expect_gap;
  logic              gap_ok;

  assign out_ready = !out_valid_r || !out_stall;
  assign adv       = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign s1_load   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign code       = state_code(state_r);
  assign retries    = code[2:0] - 3'd1;
  assign expect_gap = {{(TIME_W-GAP_W){1'b0}}, gap_r} << retries;
  assign gap_ok     = (retries < 3'(MAX_RETRIES))
                      && ((s1_item_r.time_sec - syn_time_r) == expect_gap);

  always_comb begin
    logic [7:0] fl;
    fl           = s1_item_r.flags;
    state_nxt    = state_r;
    syn_time_nxt = syn_time_r;
    bad          = 1'b0;
    unique case (state_r)
      ST_SYN, ST_RETRY1, ST_RETRY2, ST_RETRY3, ST_RETRY4, ST_RETRY5,
      ST_RETRY6: begin
        priority if (fl == FL_SYN) begin
          if (gap_ok) begin
            state_nxt    = next_retry(state_r);
            syn_time_nxt = s1_item_r.time_sec;
          end else begin
            bad       = 1'b1;
            state_nxt = ST_SYN;
          end
        end else if (fl == FL_RST_ACK) begin
          state_nxt = ST_RESET;
        end else if (fl == FL_SYN_ACK) begin
          state_nxt = ST_SYNACK;
        end else begin
          bad = 1'b1;
        end
      end
      ST_SYNACK: begin
        bad       = (fl != FL_ACK);
        state_nxt = ST_ESTAB;
      end
      ST_ESTAB: begin
        if (fl == FL_RST_ACK) begin
          state_nxt = ST_CLOSED;
        end else if (fl != FL_ACK) begin
          bad       = (fl != FL_FIN_ACK);
          state_nxt = ST_FIN1;
        end
      end
      ST_FIN1: begin
        bad       = (fl != FL_FIN_ACK);
        state_nxt = ST_FIN2;
      end
      ST_FIN2: begin
        bad       = (fl != FL_ACK);
        state_nxt = ST_CLOSED;
      end
      default: begin
        bad          = (fl != FL_SYN);
        state_nxt    = ST_SYN;
        syn_time_nxt = s1_item_r.time_sec;
      end
    endcase
    bad_cnt_nxt = (bad && (bad_cnt_r != {CNT_W{1'b1}})) ? bad_cnt_r + 1'b1 : bad_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      gap_r       <= GAP_W'(1);
      state_r     <= ST_CLOSED;
      syn_time_r  <= '0;
      bad_cnt_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        gap_r <= cfg_wr_data;
      end
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (out_ready) begin
        out_valid_r <= s1_valid_r;
      end
      if (adv) begin
        state_r    <= state_nxt;
        syn_time_r <= syn_time_nxt;
        bad_cnt_r  <= bad_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item_r <= in_item;
    end
    if (adv) begin
      out_item_r.conn_state <= state_code(state_nxt);
      out_item_r.bad_packet <= bad;
      out_item_r.bad_total  <= bad_cnt_nxt;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with an empty input register");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> bad_cnt_r >= $past(bad_cnt_r))
    else $error("bad packet count went down");

  a_bad_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.bad_packet |-> out_item_r.bad_total != '0)
    else $error("bad item reported with a zero count");

endmodule

// ----- tb/tcpct_checker.sv -----
// Checker for the TCP connection tracker: watches both channels and the gap
// register port, predicts every result item and compares it field by field.
// Depends on tcpct_pkg.
`timescale 1ns / 1ps

module tcpct_checker
  import tcpct_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_item_t          in_item,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_item_t         out_item,
  input  logic              cfg_wr_en,
  input  logic [GAP_W-1:0]  cfg_wr_data,
  output logic [CODE_W-1:0] track_code,
  output logic [TIME_W-1:0] track_syn_time,
  output logic [31:0]       awaiting,
  output logic [31:0]       fail_count
);

  logic [CODE_W-1:0] cur_code;
  logic [TIME_W-1:0] syn_stamp;
  logic [CNT_W-1:0]  bad_seen;
  logic [GAP_W-1:0]  retry_gap;
  out_item_t         awaited_results[$];
  int unsigned       fails;
  int unsigned       result_idx;

  assign track_code     = cur_code;
  assign track_syn_time = syn_stamp;
  assign awaiting       = awaited_results.size();
  assign fail_count     = fails;

  task automatic track_packet(input in_item_t pkt, output out_item_t res);
    logic [CODE_W-1:0] code;
    logic              bad;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] stride;
    int unsigned       k;
    code = cur_code;
    bad = 1'b0;
    if (code >= CODE_SYN && code < CODE_SYNACK) begin
      k = code - CODE_SYN;
      elapsed = pkt.time_sec - syn_stamp;
      stride = {{(TIME_W-GAP_W){1'b0}}, retry_gap} << k;
      if (pkt.flags == FL_SYN) begin
        if (k < MAX_RETRIES && elapsed == stride) begin
          code = code + 1'b1;
          syn_stamp = pkt.time_sec;
        end else begin
          bad = 1'b1;
          code = CODE_SYN;
        end
      end else if (pkt.flags == FL_RST_ACK) begin
        code = CODE_RESET;
      end else if (pkt.flags == FL_SYN_ACK) begin
        code = CODE_SYNACK;
      end else begin
        bad = 1'b1;
      end
    end else begin
      case (code)
        CODE_SYNACK: begin
          bad = (pkt.flags != FL_ACK);
          code = CODE_ESTAB;
        end
        CODE_ESTAB: begin
          if (pkt.flags == FL_RST_ACK) begin
            code = CODE_CLOSED;
          end else if (pkt.flags != FL_ACK) begin
            bad = (pkt.flags != FL_FIN_ACK);
            code = CODE_FIN1;
          end
        end
        CODE_FIN1: begin
          bad = (pkt.flags != FL_FIN_ACK);
          code = CODE_FIN2;
        end
        CODE_FIN2: begin
          bad = (pkt.flags != FL_ACK);
          code = CODE_CLOSED;
        end
        default: begin
          bad = (pkt.flags != FL_SYN);
          code = CODE_SYN;
          syn_stamp = pkt.time_sec;
        end
      endcase
    end
    if (bad && bad_seen != '1) begin
      bad_seen = bad_seen + 1'b1;
    end
    cur_code = code;
    res.conn_state = code;
    res.bad_packet = bad;
    res.bad_total = bad_seen;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      cur_code = CODE_CLOSED;
      syn_stamp = '0;
      bad_seen = '0;
      retry_gap = 8'd1;
      awaited_results.delete();
      fails = 0;
      result_idx = 0;
    end else begin
      if (cfg_wr_en) begin
        retry_gap = cfg_wr_data;
      end
      if (out_valid && !out_stall) begin
        got = out_item;
        if (awaited_results.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("result %0d arrived with none expected: state %0d bad %0b total %0d",
                     result_idx, got.conn_state, got.bad_packet, got.bad_total);
          end
        end else begin
          want = awaited_results.pop_front();
          if (got.conn_state !== want.conn_state || got.bad_packet !== want.bad_packet ||
              got.bad_total !== want.bad_total) begin
            fails++;
            if (fails <= 10) begin
              $display("result %0d: expected state %0d bad %0b total %0d, got state %0d bad %0b total %0d",
                       result_idx, want.conn_state, want.bad_packet, want.bad_total,
                       got.conn_state, got.bad_packet, got.bad_total);
            end
          end
        end
        result_idx++;
      end
      if (in_valid && !in_stall) begin
        track_packet(in_item, want);
        awaited_results.push_back(want);
      end
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Top of the TCP connection tracker testbench: clock, reset, packet stimulus
// steered by the checker's tracked state, gap register phases and verdict.
// Depends on tcpct_pkg, tcp_connection_tracker and tcpct_checker.
`timescale 1ns / 1ps

module tb_top;
  import tcpct_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned PHASE_ITEMS  = 380;
  localparam int unsigned SETTLE_TICKS = 6;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_item;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_item;
  logic              cfg_wr_en;
  logic [GAP_W-1:0]  cfg_wr_data;
  logic [CODE_W-1:0] track_code;
  logic [TIME_W-1:0] track_syn_time;
  logic [31:0]       awaiting;
  logic [31:0]       fail_count;

  logic              calm = 1'b0;
  logic [GAP_W-1:0]  gap_now;
  int unsigned       quiet_cycles = 0;

  tcp_connection_tracker dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  tcpct_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .track_code     (track_code),
    .track_syn_time (track_syn_time),
    .awaiting       (awaiting),
    .fail_count     (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= rst_n && !calm && ($urandom_range(99) < 22);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("tcp_connection_tracker: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_packet(input logic [7:0] fl, input logic [TIME_W-1:0] t);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{flags: fl, time_sec: t};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic pick_packet(output logic [7:0] fl, output logic [TIME_W-1:0] t);
    int unsigned       roll;
    int unsigned       k;
    logic [TIME_W-1:0] stride;
    fl = 8'($urandom);
    t = $urandom;
    if ($urandom_range(99) < 8) return;
    roll = $urandom_range(99);
    if (track_code >= CODE_SYN && track_code < CODE_SYNACK) begin
      k = track_code - CODE_SYN;
      stride = {{(TIME_W-GAP_W){1'b0}}, gap_now} << k;
      if (k >= MAX_RETRIES) begin
        if (roll < 30) fl = FL_SYN;
        else if (roll < 80) fl = FL_SYN_ACK;
        else fl = FL_RST_ACK;
      end else if (roll < 75) begin
        fl = FL_SYN;
        t = track_syn_time + stride;
      end else if (roll < 81) begin
        fl = FL_SYN;
        t = track_syn_time + stride + $urandom_range(1, 3);
      end else if (roll < 91) begin
        fl = FL_SYN_ACK;
      end else if (roll < 96) begin
        fl = FL_RST_ACK;
      end
    end else begin
      case (track_code)
        CODE_SYNACK: if (roll < 85) fl = FL_ACK;
        CODE_ESTAB: begin
          if (roll < 50) fl = FL_ACK;
          else if (roll < 85) fl = FL_FIN_ACK;
          else fl = FL_RST_ACK;
        end
        CODE_FIN1: if (roll < 85) fl = FL_FIN_ACK;
        CODE_FIN2: if (roll < 85) fl = FL_ACK;
        default: begin
          if (roll < 90) fl = FL_SYN;
          if ($urandom_range(3) == 0) t = 32'hFFFF_FFFF - $urandom_range(2000);
        end
      endcase
    end
  endtask

  task automatic random_phase(input int unsigned count, input logic quiet_span);
    logic [7:0]        fl;
    logic [TIME_W-1:0] t;
    for (int unsigned i = 0; i < count; i++) begin
      calm = quiet_span && i >= 100 && i < 300;
      pick_packet(fl, t);
      send_packet(fl, t);
    end
    calm = 1'b0;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(negedge clk); while (awaiting != 0);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  task automatic write_gap(input logic [GAP_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    gap_now = value;
    @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    gap_now = 8'd1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_packet(FL_SYN, 32'd0);
    send_packet(FL_SYN, 32'd1);
    send_packet(FL_SYN, 32'd3);
    send_packet(FL_SYN, 32'd7);
    send_packet(FL_SYN, 32'd15);
    send_packet(FL_SYN, 32'd31);
    send_packet(FL_SYN, 32'd63);
    send_packet(FL_SYN, 32'd127);
    send_packet(FL_SYN, 32'd64);
    send_packet(8'h01, 32'd70);
    send_packet(FL_SYN_ACK, 32'd71);
    send_packet(8'hFF, 32'd72);
    send_packet(FL_ACK, 32'd73);
    send_packet(8'h00, 32'd74);
    send_packet(8'hFF, 32'd75);
    send_packet(8'h00, 32'd76);
    send_packet(8'h80, 32'hFFFF_FFFF);
    send_packet(FL_SYN, 32'd0);
    send_packet(FL_SYN, 32'd5);
    send_packet(FL_RST_ACK, 32'd6);
    send_packet(FL_SYN, 32'hFFFF_FFFE);
    send_packet(FL_SYN_ACK, 32'd0);
    send_packet(FL_ACK, 32'd1);
    send_packet(FL_FIN_ACK, 32'd2);
    send_packet(FL_FIN_ACK, 32'd3);
    send_packet(FL_ACK, 32'd4);
    send_packet(FL_RST_ACK, 32'd5);

    random_phase(PHASE_ITEMS, 1'b0);
    drain();
    write_gap(8'd255);
    random_phase(PHASE_ITEMS, 1'b0);
    drain();
    write_gap(8'd0);
    random_phase(PHASE_ITEMS, 1'b1);
    drain();
    write_gap(8'($urandom_range(2, 254)));
    random_phase(PHASE_ITEMS, 1'b0);
    drain();
    write_gap(8'd1);
    random_phase(PHASE_ITEMS, 1'b0);
    drain();

    if (fail_count == 0) begin
      $display("tcp_connection_tracker: match");
    end else begin
      $display("tcp_connection_tracker: mismatch");
    end
    $finish;
  end

endmodule
